/* rtl/core/sdvc_pkg.sv */
`default_nettype none
package sdvc_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int CNT_W         = 32;
    localparam int IO_KEY_W      = 32;
    localparam int CMD_W         = 2;
    localparam int RANK_W        = 6;
    localparam int STATUS_W      = 2;
    localparam int TOTAL_W       = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic is_read;
        logic bump;
        logic insert;
    } cell_ctrl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == '1) ? c : c + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sdvc_req_if.sv */
`default_nettype none
interface sdvc_req_if;
    import sdvc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [IO_KEY_W-1:0] sample_key;
    logic [RANK_W-1:0]          rank_index;

    modport source (output valid, output cmd, output sample_key, output rank_index,
                     input ready);
    modport sink   (input valid, input cmd, input sample_key, input rank_index,
                     output ready);
endinterface
`default_nettype wire

/* rtl/core/sdvc_rsp_if.sv */
`default_nettype none
interface sdvc_rsp_if;
    import sdvc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [RANK_W-1:0]          position;
    logic signed [IO_KEY_W-1:0] value_out;
    logic [CNT_W-1:0]           count_out;
    logic [TOTAL_W-1:0]         distinct_total;

    modport source (output valid, output status, output position, output value_out,
                     output count_out, output distinct_total, input ready);
    modport sink   (input valid, input status, input position, input value_out,
                     input count_out, input distinct_total, output ready);
endinterface
`default_nettype wire

/* rtl/core/sdvc_cell.sv */
`default_nettype none
module sdvc_cell #(
    parameter int IDX       = 0,
    parameter int CAPACITY  = sdvc_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = sdvc_pkg::KEY_WIDTH_DEF,
    localparam int IW = $clog2(CAPACITY),
    localparam int NW = $clog2(CAPACITY + 1),
    localparam int LW = 1 + IW + KEY_WIDTH + sdvc_pkg::CNT_W + IW
) (
    input  wire                             clk,
    input  wire sdvc_pkg::cell_ctrl_t       ctrl,
    input  wire logic signed [KEY_WIDTH-1:0] key,
    input  wire logic [sdvc_pkg::RANK_W-1:0] rank_index,
    input  wire logic [NW-1:0]              n,
    input  wire logic signed [KEY_WIDTH-1:0] prev_key,
    input  wire logic [sdvc_pkg::CNT_W-1:0]  prev_count,
    input  wire logic                       prev_lt,
    output logic signed [KEY_WIDTH-1:0]     key_out,
    output logic [sdvc_pkg::CNT_W-1:0]      count_out,
    output logic                            lt_out,
    output logic [LW-1:0]                   leaf
);
    import sdvc_pkg::*;

    logic signed [KEY_WIDTH-1:0] key_reg,   key_next;
    logic [CNT_W-1:0]            cnt_reg,   cnt_next;
    logic                        lt_reg,    lt_next;
    logic                        match_reg, match_next;
    logic                        in_use;
    logic                        bnd;
    logic                        shift;

    assign in_use = 32'(IDX) < 32'(n);
    assign bnd    = !lt_reg && prev_lt;
    assign shift  = !prev_lt;

    always_comb
    begin
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        lt_next    = lt_reg;
        match_next = match_reg;
        if (ctrl.capture)
        begin
            lt_next = in_use && (key_reg < key);
            if (ctrl.is_read)
                match_next = in_use && (32'(rank_index) == 32'(IDX));
            else
                match_next = in_use && (key_reg == key);
        end
        if (ctrl.bump && match_reg)
            cnt_next = sat_inc(cnt_reg);
        if (ctrl.insert)
        begin
            if (shift)
            begin
                key_next = prev_key;
                cnt_next = prev_count;
            end
            else if (bnd)
            begin
                key_next = key;
                cnt_next = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        cnt_reg   <= cnt_next;
        lt_reg    <= lt_next;
        match_reg <= match_next;
    end

    assign key_out   = key_reg;
    assign count_out = cnt_reg;
    assign lt_out    = lt_reg;
    assign leaf = {match_reg,
                   match_reg ? IW'(IDX) : IW'(0),
                   match_reg ? key_reg : KEY_WIDTH'(0),
                   match_reg ? cnt_reg : CNT_W'(0),
                   bnd ? IW'(IDX) : IW'(0)};

endmodule
`default_nettype wire

/* rtl/core/sdvc_or_tree.sv */
`default_nettype none
module sdvc_or_tree #(
    parameter int N = 64,
    parameter int W = 8
) (
    input  wire             clk,
    input  wire logic [N*W-1:0] leaves,
    output logic [W-1:0]    root
);
    localparam int LOGN = $clog2(N);
    localparam int G    = 1 << ((LOGN + 1) / 2);
    localparam int NG   = (N + G - 1) / G;

    logic [W-1:0] grp_reg  [NG];
    logic [W-1:0] grp_next [NG];
    logic [W-1:0] root_reg, root_next;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int m = 0; m < G; m++)
            begin
                if (g * G + m < N)
                    grp_next[g] = grp_next[g] | leaves[(g * G + m) * W +: W];
            end
        end
    end

    always_comb
    begin
        root_next = '0;
        for (int g = 0; g < NG; g++)
            root_next = root_next | grp_reg[g];
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
            grp_reg[g] <= grp_next[g];
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule
`default_nettype wire

/* rtl/core/sorted_distinct_value_counter_top.sv */
// Sorted distinct-value counter.
// req channel (valid/ready): cmd, sample_key, rank_index. rsp channel (valid/ready):
// status, position, value_out, count_out, distinct_total; one response per request.
// Keys sit in a row of CAPACITY cells in ascending signed order, each cell holding one
// key and its count. An accepted request passes a compare state, in which every cell
// compares its key, then a registered two-level OR tree that gathers the matching
// cell and the insertion rank, and an update state that applies the update (count
// bump, or shift-and-insert along the row) and registers the response.
// The block takes no new request until the current one has left its update state; the
// compare and tree stages of one request finish before the next one enters.
// The response sits in an output register, so a new request is taken while the
// previous response still waits. If the receiver stalls, the block holds in its
// update cycle until the output register frees up.
// Reset empties the table (distinct count to zero) and drops any pending response;
// the cell contents need no clearing, since only ranks below the distinct count
// are ever read.
`default_nettype none
module sorted_distinct_value_counter_top #(
    parameter int CAPACITY  = sdvc_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = sdvc_pkg::KEY_WIDTH_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    sdvc_req_if.sink  req,
    sdvc_rsp_if.source rsp
);
    import sdvc_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int LW = 1 + IW + KEY_WIDTH + CNT_W + IW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_TR1  = 5'b00100,
        S_TR2  = 5'b01000,
        S_UPD  = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    cmd_t                        cmd_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic [RANK_W-1:0]           rank_reg;
    logic [NW-1:0]               n_reg, n_next;

    logic                        rsp_valid_reg, rsp_valid_next;
    status_t                     status_reg, status_next;
    logic [RANK_W-1:0]           pos_reg, pos_next;
    logic [IO_KEY_W-1:0]         value_reg, value_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [TOTAL_W-1:0]          total_reg, total_next;

    logic signed [63:0]          in_wide;
    logic signed [63:0]          hit_wide;
    logic signed [63:0]          new_wide;

    cell_ctrl_t                  ctrl;
    logic                        req_take;
    logic                        upd_go;
    logic                        full;

    logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CNT_W-1:0]            cell_cnt [CAPACITY];
    logic                        cell_lt  [CAPACITY];
    logic [CAPACITY*LW-1:0]      leaves;
    logic [LW-1:0]               root;

    logic                        r_hit;
    logic [IW-1:0]               r_idx;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]            r_cnt;
    logic [IW-1:0]               r_bnd;

    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;
    assign upd_go    = (state_reg == S_UPD) && (!rsp_valid_reg || rsp.ready);
    assign full      = (n_reg == NW'(CAPACITY));
    assign in_wide   = 64'(req.sample_key);

    assign {r_hit, r_idx, r_key, r_cnt, r_bnd} = root;
    assign hit_wide = 64'(r_key);
    assign new_wide = 64'(key_reg);

    always_comb
    begin
        ctrl.capture = (state_reg == S_CMP);
        ctrl.is_read = (cmd_reg == CMD_READ);
        ctrl.bump    = upd_go && (cmd_reg == CMD_ADD) && r_hit;
        ctrl.insert  = upd_go && (cmd_reg == CMD_ADD) && !r_hit && !full;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req_take) state_next = S_CMP;
            S_CMP:  state_next = S_TR1;
            S_TR1:  state_next = S_TR2;
            S_TR2:  state_next = S_UPD;
            S_UPD:  if (upd_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        n_next      = n_reg;
        status_next = STAT_OK;
        pos_next    = '0;
        value_next  = '0;
        count_next  = '0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (r_hit)
                begin
                    pos_next   = RANK_W'(r_idx);
                    value_next = hit_wide[IO_KEY_W-1:0];
                    count_next = sat_inc(r_cnt);
                end
                else if (full)
                    status_next = STAT_FULL;
                else
                begin
                    pos_next   = RANK_W'(r_bnd);
                    value_next = new_wide[IO_KEY_W-1:0];
                    count_next = CNT_W'(1);
                    n_next     = n_reg + NW'(1);
                end
            end
            CMD_LOOKUP, CMD_READ:
            begin
                if (r_hit)
                begin
                    pos_next   = RANK_W'(r_idx);
                    value_next = hit_wide[IO_KEY_W-1:0];
                    count_next = r_cnt;
                end
                else
                    status_next = STAT_MISS;
            end
            CMD_CLEAR: n_next = '0;
            default: n_next = n_reg;
        endcase
        total_next = TOTAL_W'(n_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (upd_go)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (upd_go)
                n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg  <= cmd_t'(req.cmd);
            key_reg  <= in_wide[KEY_WIDTH-1:0];
            rank_reg <= req.rank_index;
        end
        if (upd_go)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            value_reg  <= value_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [KEY_WIDTH-1:0] p_key;
        logic [CNT_W-1:0]            p_cnt;
        logic                        p_lt;

        if (i == 0)
        begin : g_head
            assign p_key = '0;
            assign p_cnt = '0;
            assign p_lt  = 1'b1;
        end
        else
        begin : g_body
            assign p_key = cell_key[i-1];
            assign p_cnt = cell_cnt[i-1];
            assign p_lt  = cell_lt[i-1];
        end

        sdvc_cell #(
            .IDX       (i),
            .CAPACITY  (CAPACITY),
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (key_reg),
            .rank_index (rank_reg),
            .n          (n_reg),
            .prev_key   (p_key),
            .prev_count (p_cnt),
            .prev_lt    (p_lt),
            .key_out    (cell_key[i]),
            .count_out  (cell_cnt[i]),
            .lt_out     (cell_lt[i]),
            .leaf       (leaves[i*LW +: LW])
        );
    end

    sdvc_or_tree #(
        .N (CAPACITY),
        .W (LW)
    ) u_tree (
        .clk    (clk),
        .leaves (leaves),
        .root   (root)
    );

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.position       = pos_reg;
    assign rsp.value_out      = value_reg;
    assign rsp.count_out      = count_reg;
    assign rsp.distinct_total = total_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(CAPACITY))
        else $error("distinct count above capacity");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == STAT_FULL) |-> rsp.distinct_total == TOTAL_W'(CAPACITY))
        else $error("full status with free entries");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != STAT_OK)
        |-> (rsp.position == '0) && (rsp.value_out == '0) && (rsp.count_out == '0))
        else $error("nonzero fields on error response");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready ##1 !req.ready ##1 !req.ready ##1 !req.ready)
        else $error("request taken while another is in progress");

endmodule
`default_nettype wire
